// ----- hw/rtl/besf_pkg.sv -----
`default_nettype none

package besf_pkg;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_CONNECTED = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int ROW_BANKS = 4;
  localparam int BANK_W    = 2;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [1:0] BOT_NONE  = 2'd0;
  localparam logic [1:0] BOT_LEFT  = 2'd1;
  localparam logic [1:0] BOT_MID   = 2'd2;
  localparam logic [1:0] BOT_ALL   = 2'd3;

  typedef struct packed {
    logic              wr;
    logic              pix;
    logic [BANK_W-1:0] wr_bank;
    logic              emit;
    logic              last;
    logic [BANK_W-1:0] res_bank;
    logic              top_ok;
    logic              bot_ok;
    logic              left_ok;
    logic              right_ok;
    logic              right_avail;
    logic [1:0]        bot_cnt;
  } besf_cmd_t;

  typedef struct packed {
    logic keep;
    logic last;
  } besf_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/besf_fifo.sv -----
`default_nettype none

module besf_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              push_go, pop_go;

  always_comb begin
    full    = cnt_r == CNTW'(DEPTH);
    empty   = cnt_r == '0;
    push_go = push & ~full;
    pop_go  = pop & ~empty;

    wr_ptr_nxt = wr_ptr_r;
    if (push_go) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop_go) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    cnt_nxt = cnt_r + CNTW'(push_go) - CNTW'(pop_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- hw/rtl/besf_front.sv -----
`default_nettype none

module besf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_op,
  input  logic                             in_pixel,
  output logic                             in_full,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [besf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [besf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             cmd_push,
  output besf_pkg::besf_cmd_t              cmd,
  output logic [$clog2(MAX_WIDTH)-1:0]     cmd_wr_col,
  output logic [$clog2(MAX_WIDTH)-1:0]     cmd_res_col,
  input  logic                             cmd_full,
  output logic                             eight_conn
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int BW    = besf_pkg::BANK_W;
  localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  function automatic int clamp_geom(int v, int hi);
    int r;
    r = v;
    if (v < 1) begin
      r = 1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic [WW-1:0] img_w_r, img_w_nxt;
  logic [HW-1:0] img_h_r, img_h_nxt;
  logic          eight_r, eight_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] res_col_r, res_col_nxt;
  logic [RW-1:0] res_row_r, res_row_nxt;
  logic [PW-1:0] pend_r, pend_nxt;

  logic          accept, active, pix_go, drain_go, emit, restart;
  logic [PW-1:0] w_p1;
  logic          pend_full, pend_eq_w;
  logic          res_right, res_bottom, in_right;

  always_comb begin
    in_full   = cmd_full;
    cfg_ready = 1'b1;
    accept    = in_push & ~cmd_full;
    active    = in_row_r < img_h_r;
    pix_go    = (in_op == besf_pkg::OP_PIXEL) & active;
    drain_go  = (in_op == besf_pkg::OP_DRAIN) & (pend_r != '0);
    w_p1      = PW'(img_w_r) + PW'(1);
    pend_full = pend_r >= w_p1;
    pend_eq_w = pend_r == PW'(img_w_r);
    emit      = pix_go ? pend_full : drain_go;

    res_right  = WW'(res_col_r) == (img_w_r - WW'(1));
    res_bottom = HW'(res_row_r) == (img_h_r - HW'(1));
    in_right   = WW'(in_col_r) == (img_w_r - WW'(1));

    cmd.wr          = pix_go;
    cmd.pix         = in_pixel;
    cmd.wr_bank     = in_row_r[BW-1:0];
    cmd.emit        = emit;
    cmd.last        = res_right & res_bottom;
    cmd.res_bank    = res_row_r[BW-1:0];
    cmd.top_ok      = res_row_r != '0;
    cmd.bot_ok      = ~res_bottom;
    cmd.left_ok     = res_col_r != '0;
    cmd.right_ok    = ~res_right;
    cmd.right_avail = pix_go | (pend_r >= PW'(2));
    if (pix_go) begin
      cmd.bot_cnt = besf_pkg::BOT_ALL;
    end else if (pend_full) begin
      cmd.bot_cnt = besf_pkg::BOT_MID;
    end else if (pend_eq_w) begin
      cmd.bot_cnt = besf_pkg::BOT_LEFT;
    end else begin
      cmd.bot_cnt = besf_pkg::BOT_NONE;
    end
    cmd_wr_col  = in_col_r;
    cmd_res_col = res_col_r;
    cmd_push    = accept & (pix_go | drain_go);

    img_w_nxt   = img_w_r;
    img_h_nxt   = img_h_r;
    eight_nxt   = eight_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    res_col_nxt = res_col_r;
    res_row_nxt = res_row_r;
    pend_nxt    = pend_r;
    restart     = 1'b0;

    if (accept) begin
      if (pix_go) begin
        if (in_right) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + HW'(1);
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
        pend_nxt = emit ? pend_r : pend_r + PW'(1);
      end else if (drain_go) begin
        pend_nxt = pend_r - PW'(1);
      end
      if (emit) begin
        if (res_right) begin
          res_col_nxt = '0;
          res_row_nxt = res_row_r + RW'(1);
        end else begin
          res_col_nxt = res_col_r + CW'(1);
        end
        if (cmd.last) begin
          restart = 1'b1;
        end
      end
    end

    if (cfg_valid) begin
      if (cfg_index == besf_pkg::CFG_IMAGE_WIDTH) begin
        img_w_nxt = WW'(clamp_geom(int'(cfg_data[besf_pkg::IMG_WIDTH_W-1:0]), MAX_WIDTH));
        restart   = 1'b1;
      end else if (cfg_index == besf_pkg::CFG_IMAGE_HEIGHT) begin
        img_h_nxt = HW'(clamp_geom(int'(cfg_data[besf_pkg::IMG_HEIGHT_W-1:0]), MAX_HEIGHT));
        restart   = 1'b1;
      end else if (cfg_index == besf_pkg::CFG_EIGHT_CONNECTED) begin
        eight_nxt = cfg_data[0];
      end
    end

    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      res_col_nxt = '0;
      res_row_nxt = '0;
      pend_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= WW'(W_RST);
      img_h_r   <= HW'(H_RST);
      eight_r   <= 1'b0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      res_col_r <= '0;
      res_row_r <= '0;
      pend_r    <= '0;
    end else begin
      img_w_r   <= img_w_nxt;
      img_h_r   <= img_h_nxt;
      eight_r   <= eight_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      res_col_r <= res_col_nxt;
      res_row_r <= res_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  assign eight_conn = eight_r;

endmodule

`default_nettype wire

// ----- hw/rtl/besf_back.sv -----
`default_nettype none

module besf_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_empty,
  input  besf_pkg::besf_cmd_t          cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0] cmd_wr_col,
  input  logic [$clog2(MAX_WIDTH)-1:0] cmd_res_col,
  output logic                         cmd_pop,
  input  logic                         eight_conn,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic                         out_keep,
  output logic                         out_last
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int NB    = besf_pkg::ROW_BANKS;
  localparam int BW    = besf_pkg::BANK_W;
  localparam int OD    = besf_pkg::OUT_DEPTH;
  localparam int CRD_W = $clog2(OD + 1);

  logic [CW-1:0]       col_p1;
  logic [NB-1:0]       rd_c, rd_c1;
  logic                pop_go, out_take;
  logic [CRD_W-1:0]    crd_r, crd_nxt;
  logic                s1_vld_r;
  besf_pkg::besf_cmd_t s1_cmd_r;
  logic [2:0]          hist_r;
  logic                left_top_r, left_mid_r;
  logic [BW-1:0]       up_bank;
  logic                tl, tm, tr, ml, ctr, mr, bl, bm, br;
  logic [2:0]          bot;
  logic [3:0]          deg4, deg8, deg;
  besf_pkg::besf_res_t res_in, res_out;

  // row store, one bank per row modulo four, read at the center and right columns
  assign col_p1 = cmd_res_col + CW'(1);

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic mem_r [MAX_WIDTH];
    logic rd_c_r, rd_c1_r;
    always_ff @(posedge clk) begin
      if (pop_go && cmd.wr && (cmd.wr_bank == BW'(b))) begin
        mem_r[cmd_wr_col] <= cmd.pix;
      end
      if (pop_go) begin
        rd_c_r  <= mem_r[cmd_res_col];
        rd_c1_r <= mem_r[col_p1];
      end
    end
    assign rd_c[b]  = rd_c_r;
    assign rd_c1[b] = rd_c1_r;
  end

  always_comb begin
    pop_go   = ~cmd_empty & (crd_r < CRD_W'(OD));
    cmd_pop  = pop_go;
    out_take = out_pop & ~out_empty;
    crd_nxt  = crd_r + CRD_W'(pop_go & cmd.emit) - CRD_W'(out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      crd_r    <= '0;
    end else begin
      s1_vld_r <= pop_go & cmd.emit;
      crd_r    <= crd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_go) begin
      s1_cmd_r <= cmd;
      if (cmd.wr) begin
        hist_r <= {hist_r[1:0], cmd.pix};
      end
    end
    if (s1_vld_r) begin
      left_top_r <= rd_c[up_bank];
      left_mid_r <= rd_c[s1_cmd_r.res_bank];
    end
  end

  // bottom row comes from the most recent pixels
  always_comb begin
    up_bank = s1_cmd_r.res_bank - BW'(1);
    case (s1_cmd_r.bot_cnt)
      besf_pkg::BOT_ALL:  bot = hist_r;
      besf_pkg::BOT_MID:  bot = {hist_r[1:0], 1'b0};
      besf_pkg::BOT_LEFT: bot = {hist_r[0], 2'b00};
      default:            bot = 3'b000;
    endcase

    tl  = left_top_r & s1_cmd_r.top_ok & s1_cmd_r.left_ok;
    tm  = rd_c[up_bank] & s1_cmd_r.top_ok;
    tr  = rd_c1[up_bank] & s1_cmd_r.top_ok & s1_cmd_r.right_ok;
    ml  = left_mid_r & s1_cmd_r.left_ok;
    ctr = rd_c[s1_cmd_r.res_bank];
    mr  = rd_c1[s1_cmd_r.res_bank] & s1_cmd_r.right_ok & s1_cmd_r.right_avail;
    bl  = bot[2] & s1_cmd_r.bot_ok & s1_cmd_r.left_ok;
    bm  = bot[1] & s1_cmd_r.bot_ok;
    br  = bot[0] & s1_cmd_r.bot_ok & s1_cmd_r.right_ok;

    deg4 = 4'(tm) + 4'(ml) + 4'(mr) + 4'(bm);
    deg8 = deg4 + 4'(tl) + 4'(tr) + 4'(bl) + 4'(br);
    deg  = eight_conn ? deg8 : deg4;

    res_in.keep = ctr & (deg != 4'd1);
    res_in.last = s1_cmd_r.last;
  end

  besf_fifo #(
    .DATA_W ($bits(besf_pkg::besf_res_t)),
    .DEPTH  (OD)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s1_vld_r),
    .din   (res_in),
    .full  (),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_keep = res_out.keep;
  assign out_last = res_out.last;

endmodule

`default_nettype wire

// ----- hw/rtl/binary_endpoint_strip_filter_core.sv -----
// path: a result passes the command queue, the row-store read register and the output queue
// throughput: one per cycle on each side unless full or empty; results in input order
// row store: four banks of one bit per column, one write and two reads per cycle
// reset: synchronous active-low rst_n clears queues, positions and pending count,
// sets width 1024, height 1024, four-neighbor mode; the row store is not cleared
`default_nettype none

module binary_endpoint_strip_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic                            in_op,
  input  logic                            in_pixel,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_keep,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [besf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [besf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CMD_W = $bits(besf_pkg::besf_cmd_t) + 2 * CW;

  logic                cmd_push, cmd_full, cmd_pop, cmd_empty, eight_conn;
  besf_pkg::besf_cmd_t f_cmd, b_cmd;
  logic [CW-1:0]       f_wr_col, f_res_col, b_wr_col, b_res_col;
  logic [CMD_W-1:0]    q_din, q_dout;

  besf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_op       (in_op),
    .in_pixel    (in_pixel),
    .in_full     (in_full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_push    (cmd_push),
    .cmd         (f_cmd),
    .cmd_wr_col  (f_wr_col),
    .cmd_res_col (f_res_col),
    .cmd_full    (cmd_full),
    .eight_conn  (eight_conn)
  );

  assign q_din = {f_cmd, f_wr_col, f_res_col};

  besf_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (besf_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (q_din),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (cmd_empty)
  );

  assign {b_cmd, b_wr_col, b_res_col} = q_dout;

  besf_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty   (cmd_empty),
    .cmd         (b_cmd),
    .cmd_wr_col  (b_wr_col),
    .cmd_res_col (b_res_col),
    .cmd_pop     (cmd_pop),
    .eight_conn  (eight_conn),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_keep    (out_keep),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

// ----- test/binary_endpoint_strip_filter_core_tb.sv -----
`timescale 1ns / 1ps

module binary_endpoint_strip_filter_core_tb;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 100;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [besf_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam logic [8:0] FOUR_NEIGHBORS  = 9'h0AA;
  localparam logic [8:0] EIGHT_NEIGHBORS = 9'h1EF;

  typedef enum logic [2:0] {K_ITEM, K_CONFIG, K_SETTLE, K_IDLING, K_HOLD} stim_kind_t;

  typedef struct {
    stim_kind_t                      kind;
    logic                            op;
    logic                            pixel;
    logic [besf_pkg::CFG_IDX_W-1:0]  index;
    logic [besf_pkg::CFG_DATA_W-1:0] data;
    int                              sender_pct;
    int                              receiver_pct;
  } stim_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic                            in_op = 1'b0;
  logic                            in_pixel = 1'b0;
  logic                            in_full;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  logic                            out_keep;
  logic                            out_last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [besf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [besf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stim_t               stim_q[$];
  besf_pkg::besf_res_t strip_results_q[$];
  int                  results_predicted = 0;
  int                  results_seen = 0;
  int                  mismatches = 0;
  int                  sender_idle = 0;
  int                  receiver_stall = 0;
  int                  idle_run = 0;
  int                  hold_requests = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  cycle_count = 0;
  logic                all_sent = 1'b0;

  // filter state as the block should hold it
  bit row_bits [4][MAX_W];
  int rx_col = 0;
  int rx_row = 0;
  int emitted = 0;
  int res_col = 0;
  int res_row = 0;
  int width_cfg = 1024;
  int height_cfg = 1024;
  bit eight_cfg = 1'b0;

  binary_endpoint_strip_filter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_op     (in_op),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_keep  (out_keep),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void restart_image();
    rx_col  = 0;
    rx_row  = 0;
    emitted = 0;
    res_col = 0;
    res_row = 0;
  endfunction

  function automatic bit window_bit(int y, int x);
    if (y < 0 || x < 0 || y >= height_cfg || x >= width_cfg) return 1'b0;
    if (y > rx_row || (y == rx_row && x >= rx_col)) return 1'b0;
    return row_bits[y % 4][x];
  endfunction

  function automatic void emit_strip_result();
    logic [8:0]          win;
    int                  degree;
    besf_pkg::besf_res_t res;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        win[dy * 3 + dx] = window_bit(res_row - 1 + dy, res_col - 1 + dx);
      end
    end
    degree   = $countones(win & (eight_cfg ? EIGHT_NEIGHBORS : FOUR_NEIGHBORS));
    res.keep = win[4] && (degree != 1);
    res.last = (res_row == height_cfg - 1) && (res_col == width_cfg - 1);
    strip_results_q.push_back(res);
    results_predicted++;
    emitted++;
    res_col++;
    if (res_col >= width_cfg) begin
      res_col = 0;
      res_row++;
    end
    if (res.last) restart_image();
  endfunction

  function automatic void strip_filter_step(logic op, logic pix);
    if (op == besf_pkg::OP_PIXEL) begin
      if (rx_row >= height_cfg) return;
      row_bits[rx_row % 4][rx_col] = pix;
      rx_col++;
      if (rx_col >= width_cfg) begin
        rx_col = 0;
        rx_row++;
      end
      if (rx_row * width_cfg + rx_col - emitted > width_cfg + 1) emit_strip_result();
    end else begin
      if (rx_row * width_cfg + rx_col - emitted > 0) emit_strip_result();
    end
  endfunction

  function automatic void write_filter_register(logic [besf_pkg::CFG_IDX_W-1:0] idx,
                                                logic [besf_pkg::CFG_DATA_W-1:0] data);
    int v;
    case (idx)
      besf_pkg::CFG_IMAGE_WIDTH: begin
        v = data[besf_pkg::IMG_WIDTH_W-1:0];
        width_cfg = (v < 1) ? 1 : (v > MAX_W) ? MAX_W : v;
        restart_image();
      end
      besf_pkg::CFG_IMAGE_HEIGHT: begin
        v = data[besf_pkg::IMG_HEIGHT_W-1:0];
        height_cfg = (v < 1) ? 1 : (v > MAX_H) ? MAX_H : v;
        restart_image();
      end
      besf_pkg::CFG_EIGHT_CONNECTED: begin
        eight_cfg = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  task automatic add_item(logic op, logic pix);
    stim_q.push_back('{kind: K_ITEM, op: op, pixel: pix, index: '0, data: '0,
                       sender_pct: 0, receiver_pct: 0});
  endtask

  task automatic add_register(logic [besf_pkg::CFG_IDX_W-1:0] idx,
                              logic [besf_pkg::CFG_DATA_W-1:0] data);
    stim_q.push_back('{kind: K_CONFIG, op: 1'b0, pixel: 1'b0, index: idx, data: data,
                       sender_pct: 0, receiver_pct: 0});
  endtask

  task automatic add_idling(int sender_pct, int receiver_pct);
    stim_q.push_back('{kind: K_IDLING, op: 1'b0, pixel: 1'b0, index: '0, data: '0,
                       sender_pct: sender_pct, receiver_pct: receiver_pct});
  endtask

  always @(posedge clk) begin : pixel_driver
    logic  push_nxt;
    logic  valid_nxt;
    stim_t head;
    if (!rst_n) begin
      in_push   <= 1'b0;
      cfg_valid <= 1'b0;
      idle_run  = 0;
    end else begin
      push_nxt  = in_push;
      valid_nxt = cfg_valid;
      if (in_push && !in_full) begin
        strip_filter_step(in_op, in_pixel);
        push_nxt = 1'b0;
        idle_run = 0;
      end else if (idle_run < 1000) begin
        idle_run++;
      end
      if (cfg_valid && cfg_ready) begin
        write_filter_register(cfg_index, cfg_data);
        valid_nxt = 1'b0;
      end
      if (!push_nxt && !valid_nxt && stim_q.size() > 0) begin
        head = stim_q[0];
        case (head.kind)
          K_ITEM: begin
            if ($urandom_range(99) >= sender_idle) begin
              void'(stim_q.pop_front());
              push_nxt = 1'b1;
              in_op    <= head.op;
              in_pixel <= head.pixel;
            end
          end
          K_CONFIG: begin
            if (results_seen == results_predicted && idle_run >= SETTLE_CYCLES) begin
              void'(stim_q.pop_front());
              valid_nxt = 1'b1;
              cfg_index <= head.index;
              cfg_data  <= head.data;
            end
          end
          K_SETTLE: begin
            if (results_seen == results_predicted && idle_run >= SETTLE_CYCLES) begin
              void'(stim_q.pop_front());
            end
          end
          K_IDLING: begin
            void'(stim_q.pop_front());
            sender_idle = head.sender_pct;
            receiver_stall <= head.receiver_pct;
          end
          K_HOLD: begin
            void'(stim_q.pop_front());
            hold_requests <= hold_requests + 1;
          end
          default: begin
          end
        endcase
      end
      in_push   <= push_nxt;
      cfg_valid <= valid_nxt;
      all_sent  <= (stim_q.size() == 0) && !push_nxt && !valid_nxt;
    end
  end

  always @(posedge clk) begin : result_monitor
    besf_pkg::besf_res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (strip_results_q.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual keep=%0b last=%0b",
                   $time, out_keep, out_last);
          mismatches++;
        end else begin
          want = strip_results_q.pop_front();
          if (want.keep !== out_keep) begin
            $display("%0t: keep mismatch: expected %0b, actual %0b", $time, want.keep, out_keep);
            mismatches++;
          end
          if (want.last !== out_last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, out_last);
            mismatches++;
          end
          results_seen <= results_seen + 1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      out_pop <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int   phase;
    int   count;
    int   w;
    int   h;
    int   n;
    int   density;
    logic img[6];
    // single pixel image, zero geometry taken as one
    add_idling(0, 0);
    add_register(besf_pkg::CFG_EIGHT_CONNECTED, 13'h0000);
    add_register(besf_pkg::CFG_IMAGE_WIDTH, 13'h0000);
    add_register(besf_pkg::CFG_IMAGE_HEIGHT, 13'h0000);
    add_item(besf_pkg::OP_PIXEL, 1'b1);
    add_item(besf_pkg::OP_DRAIN, 1'b0);
    add_item(besf_pkg::OP_DRAIN, 1'b1);
    // 3x2 image, eight neighbors, width bits above the field masked off
    add_register(besf_pkg::CFG_EIGHT_CONNECTED, 13'h1FFF);
    add_register(besf_pkg::CFG_IMAGE_WIDTH, 13'h1803);
    add_register(besf_pkg::CFG_IMAGE_HEIGHT, 13'h0002);
    img = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    foreach (img[i]) add_item(besf_pkg::OP_PIXEL, img[i]);
    add_item(besf_pkg::OP_PIXEL, 1'b1);
    add_item(besf_pkg::OP_PIXEL, 1'b0);
    repeat (5) add_item(besf_pkg::OP_DRAIN, 1'b1);
    // widest and tallest geometry, clamped, drained early
    add_register(besf_pkg::CFG_EIGHT_CONNECTED, 13'h0000);
    add_register(besf_pkg::CFG_IMAGE_WIDTH, 13'h07FF);
    add_register(besf_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    add_register(CFG_SPARE_INDEX, 13'(($urandom_range(8191))));
    add_item(besf_pkg::OP_PIXEL, 1'b1);
    add_item(besf_pkg::OP_PIXEL, 1'b1);
    add_item(besf_pkg::OP_PIXEL, 1'b1);
    add_item(besf_pkg::OP_PIXEL, 1'b0);
    repeat (5) add_item(besf_pkg::OP_DRAIN, 1'b0);

    // receiver holds off while the sender keeps going, then the sender waits
    add_register(besf_pkg::CFG_IMAGE_WIDTH, 13'd2);
    add_register(besf_pkg::CFG_IMAGE_HEIGHT, 13'd8);
    stim_q.push_back('{kind: K_HOLD, op: 1'b0, pixel: 1'b0, index: '0, data: '0,
                       sender_pct: 0, receiver_pct: 0});
    repeat (16) add_item(besf_pkg::OP_PIXEL, 1'($urandom_range(1)));
    repeat (3) add_item(besf_pkg::OP_DRAIN, 1'b0);
    stim_q.push_back('{kind: K_SETTLE, op: 1'b0, pixel: 1'b0, index: '0, data: '0,
                       sender_pct: 0, receiver_pct: 0});

    phase = 0;
    count = 0;
    while (count < 550) begin
      case (phase % 4)
        0: add_idling(0, 0);
        1: add_idling(64, 0);
        2: add_idling(0, 64);
        default: add_idling(14, 14);
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      add_register(besf_pkg::CFG_EIGHT_CONNECTED, 13'($urandom_range(8191)));
      add_register(besf_pkg::CFG_IMAGE_WIDTH, {2'($urandom_range(3)), 11'(w)});
      add_register(besf_pkg::CFG_IMAGE_HEIGHT, 13'(h));
      repeat ($urandom_range(3, 1)) begin
        density = $urandom_range(80, 20);
        n = w * h;
        // broken image: cut short, the next geometry write restarts it
        if ($urandom_range(7) == 0) n = $urandom_range(w * h - 1, 0);
        for (int i = 0; i < n; i++) begin
          add_item(besf_pkg::OP_PIXEL, 1'($urandom_range(99) < density));
          if ($urandom_range(29) == 0) add_item(besf_pkg::OP_DRAIN, 1'($urandom_range(1)));
        end
        count += n;
        if (n < w * h) break;
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(2, 1)) add_item(besf_pkg::OP_PIXEL, 1'($urandom_range(1)));
        end
        repeat (w + 1 + $urandom_range(1)) add_item(besf_pkg::OP_DRAIN, 1'($urandom_range(1)));
        count += w + 1;
      end
      phase++;
    end

    do @(posedge clk); while (!(all_sent && results_seen == results_predicted));
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && strip_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/besf_pkg.sv
hw/rtl/besf_fifo.sv
hw/rtl/besf_front.sv
hw/rtl/besf_back.sv
hw/rtl/binary_endpoint_strip_filter_core.sv
test/binary_endpoint_strip_filter_core_tb.sv
